// File: src/frbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO ring buffer with peek: shared definitions
// Sizes, operation codes and the control bundle that the cell row uses.
// ----------------------------------------------------------------------------
package frbp_pkg;

   // Word size matches the fixed 32-bit data fields; index and count widths follow from capacity.
   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   // Operation codes carried by a request.
   typedef enum logic [1:0] {
      FUNC_PUSH  = 2'd0,
      FUNC_POP   = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_PEEK  = 2'd3
   } func_type;

   // Control from the sequencer to every cell of the row.
   typedef struct packed {
      logic             shift;
      logic             load;
      logic [IDX_W-1:0] load_pos;
   } cell_ctl_type;

endpackage

// File: src/frbp_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO request channel
// Valid/ready channel that carries one operation request.
// ----------------------------------------------------------------------------
interface frbp_req_if;
   import frbp_pkg::*;

   logic                  valid;
   logic                  ready;
   func_type              func;
   logic [31:0]           push_data;
   logic [IDX_W-1:0]      peek_index;

   modport source (output valid, func, push_data, peek_index, input ready);
   modport sink   (input valid, func, push_data, peek_index, output ready);
endinterface

// File: src/frbp_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO response channel
// Valid/ready channel that carries the result of one request.
// ----------------------------------------------------------------------------
interface frbp_rsp_if;
   import frbp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  ok;
   logic [31:0]           peek_data;
   logic [CNT_W-1:0]      fill_count;
   logic                  is_empty;
   logic                  is_full;

   modport source (output valid, ok, peek_data, fill_count, is_empty, is_full,
                   input ready);
   modport sink   (input valid, ok, peek_data, fill_count, is_empty, is_full,
                   output ready);
endinterface

// File: src/frbp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO storage cell
// Holds the word at one logical position from the head. Takes the word of
// its upper neighbor on a pop and loads new data when a push lands on it.
// ----------------------------------------------------------------------------
module frbp_cell #(
   parameter int POSITION = 0
) (
   input  logic                          clock,
   input  frbp_pkg::cell_ctl_type        ctl,
   input  logic [frbp_pkg::DATA_WIDTH-1:0] push_word,
   input  logic [frbp_pkg::DATA_WIDTH-1:0] neighbor_word,
   output logic [frbp_pkg::DATA_WIDTH-1:0] word
);
   import frbp_pkg::*;

   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] word_in;
   logic                  hit;

   // A push writes the cell that sits right above the current fill level.
   assign hit = ctl.load && (ctl.load_pos == IDX_W'(POSITION));

   // Select the next word: shift down on pop, load on a matching push.
   always_comb begin
      word_in = word_ff;
      if (ctl.shift) begin
         word_in = neighbor_word;
      end else if (hit) begin
         word_in = push_word;
      end
   end

   // Payload register, no reset needed.
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
endmodule

// File: src/frbp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO sequencer
// Tracks the fill count, steers the cell row and registers each response.
// ----------------------------------------------------------------------------
module frbp_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   frbp_req_if.sink                        req_chan,
   frbp_rsp_if.source                      rsp_chan,
   input  logic [frbp_pkg::DATA_WIDTH-1:0] peek_word,
   output frbp_pkg::cell_ctl_type          cell_ctl
);
   import frbp_pkg::*;

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  rsp_valid_ff;
   logic                  ok_ff;
   logic                  ok_in;
   logic [31:0]           data_ff;
   logic [31:0]           data_in;
   logic [CNT_W-1:0]      fill_ff;
   logic                  empty_ff;
   logic                  full_ff;
   logic                  accept;
   logic                  is_full_now;
   logic                  is_empty_now;

   // A new request enters whenever the response register is free or draining.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign is_full_now  = (count_ff == CNT_W'(DEPTH));
   assign is_empty_now = (count_ff == '0);

   // Decode the operation into a new count and the response fields.
   always_comb begin
      count_in = count_ff;
      ok_in    = 1'b0;
      data_in  = '0;
      case (req_chan.func)
         FUNC_PUSH: begin
            if (!is_full_now) begin
               count_in = count_ff + CNT_W'(1);
               ok_in    = 1'b1;
            end
         end
         FUNC_POP: begin
            if (!is_empty_now) begin
               count_in = count_ff - CNT_W'(1);
               ok_in    = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            count_in = '0;
            ok_in    = 1'b1;
         end
         FUNC_PEEK: begin
            if (CNT_W'(req_chan.peek_index) < count_ff) begin
               ok_in   = 1'b1;
               data_in = 32'(peek_word);
            end
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   // Row control: a pop shifts every cell down, a push loads one cell.
   always_comb begin
      cell_ctl.shift    = accept && (req_chan.func == FUNC_POP) && !is_empty_now;
      cell_ctl.load     = accept && (req_chan.func == FUNC_PUSH) && !is_full_now;
      cell_ctl.load_pos = count_ff[IDX_W-1:0];
   end

   // Count and response valid are control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload is captured with each accepted request.
   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff    <= ok_in;
         data_ff  <= data_in;
         fill_ff  <= count_in;
         empty_ff <= (count_in == '0);
         full_ff  <= (count_in == CNT_W'(DEPTH));
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.ok         = ok_ff;
   assign rsp_chan.peek_data  = data_ff;
   assign rsp_chan.fill_count = fill_ff;
   assign rsp_chan.is_empty   = empty_ff;
   assign rsp_chan.is_full    = full_ff;
endmodule

// File: src/fifo_ring_buffer_with_peek.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO ring buffer with peek
// Sixteen-word first-in first-out store with push, pop, clear and peek.
//
//   Channel    Dir   Content
//   req_chan   in    func, push_data, peek_index
//   rsp_chan   out   ok, peek_data, fill_count, is_empty, is_full
//
// Every request gives one registered response, held until it is read.
// A new request is taken in every cycle in which the response register is
// empty or being read, so the rate is one request per cycle.
// Reset empties the store at once; stored words need no clearing.
// A stalled response holds its register and stalls the request side.
// ----------------------------------------------------------------------------
module fifo_ring_buffer_with_peek (
   input  logic       clock,
   input  logic       reset,
   frbp_req_if.sink   req_chan,
   frbp_rsp_if.source rsp_chan
);
   import frbp_pkg::*;

   cell_ctl_type          cell_ctl;
   logic [DATA_WIDTH-1:0] cell_word [DEPTH];
   logic [DATA_WIDTH-1:0] peek_word;

   // Sequencer for count, row control and responses.
   frbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .peek_word (peek_word),
      .cell_ctl  (cell_ctl)
   );

   // Row of cells; cell zero always holds the head word.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] upper_word;

      if (i == DEPTH - 1) begin : g_last
         assign upper_word = cell_word[i];
      end else begin : g_mid
         assign upper_word = cell_word[i + 1];
      end

      frbp_cell #(
         .POSITION (i)
      ) u_cell (
         .clock         (clock),
         .ctl           (cell_ctl),
         .push_word     (DATA_WIDTH'(req_chan.push_data)),
         .neighbor_word (upper_word),
         .word          (cell_word[i])
      );
   end

   // Peek selects the cell at the requested distance from the head.
   assign peek_word = cell_word[req_chan.peek_index];
endmodule

// File: bench/tb_fifo_ring_buffer_with_peek.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO ring buffer with peek: testbench
// Drives push, pop, clear and peek requests through the request channel with
// bursty timing and a stalling response side, keeps a shadow copy of the ring,
// and checks every response field against the outcome of that shadow copy.
// ----------------------------------------------------------------------------
module tb_fifo_ring_buffer_with_peek;
   import frbp_pkg::*;

   localparam int IDLE_LIMIT   = 1000;
   localparam int RANDOM_COUNT = 700;
   localparam int PRINT_LIMIT  = 40;
   localparam int RESULT_SLOTS = 8;

   // Response fields as they should come back for one request.
   typedef struct packed {
      logic             ok;
      logic [31:0]      peek_data;
      logic [CNT_W-1:0] fill_count;
      logic             is_empty;
      logic             is_full;
   } fifo_status_type;

   logic clock = 1'b0;
   logic reset;

   frbp_req_if req_chan ();
   frbp_rsp_if rsp_chan ();

   fifo_ring_buffer_with_peek i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow copy of the ring contents and pointers.
   logic [31:0]      ring_words [DEPTH];
   int               ring_head;
   int               ring_tail;
   int               ring_count;
   int               peak_count;

   // Outcomes of accepted requests, oldest first, held in a small ring.
   fifo_status_type  result_store [RESULT_SLOTS];
   int               result_wr;
   int               result_rd;
   int               result_pending;

   int               op_count [4];
   int               refused_count [4];
   int               error_count;
   int               rsp_count;
   int               burst_left;
   int               idle_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one operation to the shadow ring and return the status it yields.
   function automatic fifo_status_type apply_fifo_op(input func_type f,
                                                     input logic [31:0] word,
                                                     input logic [IDX_W-1:0] idx);
      fifo_status_type st;
      st = '0;
      op_count[f]++;
      case (f)
         FUNC_PUSH: begin
            if (ring_count < DEPTH) begin
               ring_words[ring_tail] = word;
               ring_tail = (ring_tail + 1) % DEPTH;
               ring_count++;
               st.ok = 1'b1;
            end
         end
         FUNC_POP: begin
            if (ring_count > 0) begin
               ring_head = (ring_head + 1) % DEPTH;
               ring_count--;
               st.ok = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            // The words stay in place; only the head catches up with the tail.
            ring_head  = ring_tail;
            ring_count = 0;
            st.ok      = 1'b1;
         end
         default: begin
            if (int'(idx) < ring_count) begin
               st.peek_data = ring_words[(ring_head + int'(idx)) % DEPTH];
               st.ok        = 1'b1;
            end
         end
      endcase
      if (!st.ok) refused_count[f]++;
      if (ring_count > peak_count) peak_count = ring_count;
      st.fill_count = ring_count[CNT_W-1:0];
      st.is_empty   = (ring_count == 0);
      st.is_full    = (ring_count == DEPTH);
      return st;
   endfunction

   // Append one expected outcome.
   function automatic void store_result(input fifo_status_type st);
      result_store[result_wr] = st;
      result_wr = (result_wr + 1) % RESULT_SLOTS;
      result_pending++;
   endfunction

   // Remove and return the oldest expected outcome.
   function automatic fifo_status_type take_result();
      fifo_status_type st;
      st = result_store[result_rd];
      result_rd = (result_rd + 1) % RESULT_SLOTS;
      result_pending--;
      return st;
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("response %0d field %s is %0h, should be %0h",
                                   rsp_count, name, got, want));
   endtask

   // Send one request in bursts with random gaps, and record its outcome once
   // it is accepted. Valid stays high after acceptance for the next request.
   task automatic send_request(input func_type f, input logic [31:0] word,
                               input logic [IDX_W-1:0] idx);
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 12);
      end
      req_chan.valid      <= 1'b1;
      req_chan.func       <= f;
      req_chan.push_data  <= word;
      req_chan.peek_index <= idx;
      do @(posedge clock); while (!req_chan.ready);
      store_result(apply_fifo_op(f, word, idx));
      burst_left--;
   endtask

   // Stop sending and wait until every outstanding response has arrived.
   task automatic wait_for_idle();
      req_chan.valid <= 1'b0;
      while (result_pending != 0) @(posedge clock);
   endtask

   // Nothing can be read from an empty ring.
   task automatic test_empty_ring();
      send_request(FUNC_POP, 32'h0, '0);
      send_request(FUNC_PEEK, 32'hFFFF_FFFF, '0);
   endtask

   // Fill every slot with extreme and mixed words, then push once more.
   task automatic test_fill_to_capacity();
      logic [31:0] word;
      for (int i = 0; i < DEPTH; i++) begin
         case (i)
            0:       word = 32'h0000_0000;
            1:       word = 32'hFFFF_FFFF;
            2:       word = 32'h5555_5555;
            3:       word = 32'hAAAA_AAAA;
            default: word = 32'hC3A5_0000 + i;
         endcase
         send_request(FUNC_PUSH, word, '1);
      end
      send_request(FUNC_PUSH, 32'hDEAD_0001, '0);
   endtask

   // Peek the last slot, pop one word and push one, then peek the last slot again across the wrap.
   task automatic test_wrap_around();
      send_request(FUNC_PEEK, 32'h0, '1);
      send_request(FUNC_POP, 32'h0, '0);
      send_request(FUNC_PUSH, 32'h8000_0001, '0);
      send_request(FUNC_PEEK, 32'h0, '1);
   endtask

   // Clear a full ring; the old words must no longer be visible.
   task automatic test_clear_full();
      send_request(FUNC_CLEAR, 32'hFFFF_FFFF, '1);
      send_request(FUNC_PEEK, 32'h0, '0);
   endtask

   // Mixed traffic that alternates between filling, draining and balanced
   // phases, so the ring passes through every fill level many times.
   task automatic test_random_traffic(input int count);
      int          mode;
      int          pick;
      int          push_pct;
      int          pop_pct;
      func_type    f;
      logic [31:0] word;
      logic [IDX_W-1:0] idx;
      mode = 0;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) mode = $urandom_range(0, 2);
         case (mode)
            0:       begin push_pct = 60; pop_pct = 15; end
            1:       begin push_pct = 20; pop_pct = 55; end
            default: begin push_pct = 35; pop_pct = 35; end
         endcase
         pick = $urandom_range(0, 99);
         if (pick < push_pct)                f = FUNC_PUSH;
         else if (pick < push_pct + pop_pct) f = FUNC_POP;
         else if (pick < push_pct + pop_pct + 3) f = FUNC_CLEAR;
         else                                f = FUNC_PEEK;
         case ($urandom_range(0, 7))
            0:       word = 32'h0000_0000;
            1:       word = 32'hFFFF_FFFF;
            default: word = $urandom;
         endcase
         // Most peeks land inside the stored range, the rest anywhere.
         if (ring_count > 0 && $urandom_range(0, 4) != 0)
            idx = IDX_W'($urandom_range(0, ring_count - 1));
         else
            idx = IDX_W'($urandom_range(0, DEPTH - 1));
         send_request(f, word, idx);
      end
   endtask

   // Response side stalls on a rotating pattern that is reloaded now and then.
   initial begin
      logic [7:0] stall_pattern;
      int         cycle;
      stall_pattern = 8'hFF;
      cycle = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cycle++;
         if (cycle % 50 == 0) begin
            if ($urandom_range(0, 2) == 0) stall_pattern = 8'hFF;
            else stall_pattern = 8'($urandom) | 8'h01;
         end else begin
            stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
         end
         rsp_chan.ready <= stall_pattern[7];
      end
   end

   // Compare each accepted response with the oldest recorded outcome.
   always @(posedge clock) begin : check_responses
      fifo_status_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (result_pending == 0) begin
            report_mismatch("response arrived with no request outstanding");
         end else begin
            want = take_result();
            compare_field("ok",         rsp_chan.ok,         want.ok);
            compare_field("peek_data",  rsp_chan.peek_data,  want.peek_data);
            compare_field("fill_count", rsp_chan.fill_count, want.fill_count);
            compare_field("is_empty",   rsp_chan.is_empty,   want.is_empty);
            compare_field("is_full",    rsp_chan.is_full,    want.is_full);
         end
         rsp_count++;
      end
   end

   // End the run when neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no request or response moved for %0d cycles", IDLE_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      ring_head      = 0;
      ring_tail      = 0;
      ring_count     = 0;
      peak_count     = 0;
      result_wr      = 0;
      result_rd      = 0;
      result_pending = 0;
      error_count    = 0;
      rsp_count      = 0;
      burst_left     = 0;
      idle_cycles    = 0;
      foreach (op_count[i]) begin
         op_count[i]      = 0;
         refused_count[i] = 0;
      end
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.func       <= FUNC_PUSH;
      req_chan.push_data  <= 32'h0;
      req_chan.peek_index <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_empty_ring();
      test_fill_to_capacity();
      test_wrap_around();
      test_clear_full();
      test_random_traffic(RANDOM_COUNT);

      // Let the last response drain, then check that no response is still outstanding.
      wait_for_idle();
      repeat (4) @(posedge clock);
      if (result_pending != 0)
         report_mismatch($sformatf("%0d responses never arrived", result_pending));

      $display("Requests: %0d push (%0d refused full), %0d pop (%0d refused empty),",
               op_count[FUNC_PUSH], refused_count[FUNC_PUSH],
               op_count[FUNC_POP], refused_count[FUNC_POP]);
      $display("%0d clear, %0d peek (%0d out of range); peak fill %0d; %0d responses.",
               op_count[FUNC_CLEAR], op_count[FUNC_PEEK], refused_count[FUNC_PEEK],
               peak_count, rsp_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches found", error_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
